/* sv/wwmc_pkg.sv */
// Shared constants and register indexes for the whole-word match counter.
package wwmc_pkg;

  // Longest pattern the window compare supports
  localparam int MAX_PATTERN = 16;
  // Width of the saturating match counter
  localparam int COUNT_BITS = 16;

  // Fixed field widths
  localparam int BYTE_BITS = 8;
  localparam int LEN_BITS = 5;
  localparam int WORD_BITS = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 64;

  // Index widths derived from the pattern size
  localparam int WIN_IDX_BITS = $clog2(MAX_PATTERN + 1);
  localparam int PAT_IDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // Byte codes
  localparam logic [BYTE_BITS-1:0] SPACE_BYTE = 8'd32;
  localparam logic [BYTE_BITS-1:0] ZERO_BYTE = 8'd0;

  // Position counter saturates here
  localparam logic [LEN_BITS-1:0] POS_MAX = 5'd31;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_PATTERN_LOW = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PATTERN_LEN = 2'd2;

endpackage

/* sv/whole_word_match_counter_unit.sv */
// Whole-word pattern match counter: stream in text bytes, stream out running counts.
//
//  channel  | dir | payload                                  | accepted when
//  ---------+-----+------------------------------------------+----------------------------
//  s_axis   | in  | tdata = text_byte, tlast = last_byte     | s_axis_tvalid & s_axis_tready
//  m_axis   | out | tdata = word_count, tuser = match_confirmed,
//           |     | tlast = string_done                      | m_axis_tvalid & m_axis_tready
//  cfg      | in  | cfg_index, cfg_data                      | cfg_valid & cfg_ready
//
// One item per cycle unless stalled; each result shows the cycle after its byte is taken.
// The window compare and count update sit between the state and the output register.
// A stalled output holds the block only while the output register is full.
// Sync reset clears window, counters, pattern bytes and output valid, and sets length to 1.
// All string state clears after the item marked last.
module whole_word_match_counter_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wwmc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [wwmc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // text input
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [wwmc_pkg::BYTE_BITS-1:0]       s_axis_tdata,   // [7:0] text_byte
  input  logic                                 s_axis_tlast,
  // result output
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [wwmc_pkg::WORD_BITS-1:0]       m_axis_tdata,   // [15:0] word_count
  output logic                                 m_axis_tuser,   // [0] match_confirmed
  output logic                                 m_axis_tlast
);
  import wwmc_pkg::*;

  // configuration registers
  logic [CFG_DATA_BITS-1:0] pattern_low;
  logic [CFG_DATA_BITS-1:0] pattern_high;
  logic [LEN_BITS-1:0]      pattern_len;

  // string state
  logic [BYTE_BITS-1:0]     hist [MAX_PATTERN];
  logic [LEN_BITS-1:0]      pos;
  logic                     pending;
  logic [COUNT_BITS-1:0]    total;

  // output register
  logic                     out_valid;
  logic [WORD_BITS-1:0]     out_count;
  logic                     out_confirmed;
  logic                     out_done;

  // next values
  logic [BYTE_BITS-1:0]     win [MAX_PATTERN+1];
  logic [BYTE_BITS-1:0]     pat [MAX_PATTERN];
  logic [LEN_BITS-1:0]      len_eff;
  logic [LEN_BITS-1:0]      pos_next;
  logic                     all_eq;
  logic                     left_ok;
  logic                     hit;
  logic                     confirm_prev;
  logic                     confirm_end;
  logic [COUNT_BITS-1:0]    total_mid;
  logic [COUNT_BITS-1:0]    total_next;
  logic [WORD_BITS+COUNT_BITS-1:0] total_ext;
  logic                     accept;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // unpack pattern bytes
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pat
    if (k < 8) begin : g_low
      assign pat[k] = pattern_low[8*k +: 8];
    end else begin : g_high
      assign pat[k] = pattern_high[8*(k-8) +: 8];
    end
  end

  // window after the new byte shifts in
  assign win[0] = s_axis_tdata;
  for (genvar k = 1; k <= MAX_PATTERN; k++) begin : g_win
    assign win[k] = hist[k-1];
  end

  // clamp length, advance position
  always_comb begin
    len_eff  = (pattern_len > LEN_BITS'(MAX_PATTERN)) ? LEN_BITS'(MAX_PATTERN) : pattern_len;
    pos_next = (pos < POS_MAX) ? pos + LEN_BITS'(1) : pos;
  end

  // window compare: newest byte against the last pattern byte, older bytes against earlier ones
  always_comb begin
    logic [LEN_BITS-1:0] pidx;
    all_eq = 1'b1;
    pidx   = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pidx = len_eff - LEN_BITS'(1) - LEN_BITS'(i);
      if (LEN_BITS'(i) < len_eff && win[i] != pat[pidx[PAT_IDX_BITS-1:0]]) begin
        all_eq = 1'b0;
      end
    end
  end

  // word boundaries and count update
  always_comb begin
    left_ok      = (pos_next == len_eff) ||
                   (win[len_eff[WIN_IDX_BITS-1:0]] == SPACE_BYTE);
    hit          = (len_eff != '0) && (pos_next >= len_eff) && all_eq && left_ok;
    confirm_prev = pending && (s_axis_tdata == SPACE_BYTE || s_axis_tdata == ZERO_BYTE);
    confirm_end  = hit && s_axis_tlast;
    total_mid    = (confirm_prev && total != '1) ? total + COUNT_BITS'(1) : total;
    total_next   = (confirm_end && total_mid != '1) ? total_mid + COUNT_BITS'(1) : total_mid;
    total_ext    = {{WORD_BITS{1'b0}}, total_next};
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low  <= '0;
      pattern_high <= '0;
      pattern_len  <= LEN_BITS'(1);
      for (int i = 0; i < MAX_PATTERN; i++) hist[i] <= '0;
      pos          <= '0;
      pending      <= 1'b0;
      total        <= '0;
      out_valid    <= 1'b0;
    end else begin
      // config writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PATTERN_LOW:  pattern_low  <= cfg_data;
          CFG_PATTERN_HIGH: pattern_high <= cfg_data;
          CFG_PATTERN_LEN:  pattern_len  <= cfg_data[LEN_BITS-1:0];
          default: ;
        endcase
      end

      // output handshake
      if (m_axis_tvalid && m_axis_tready) out_valid <= 1'b0;

      // take one text item
      if (accept) begin
        out_valid     <= 1'b1;
        out_count     <= total_ext[WORD_BITS-1:0];
        out_confirmed <= confirm_prev || confirm_end;
        out_done      <= s_axis_tlast;
        if (s_axis_tlast) begin
          for (int i = 0; i < MAX_PATTERN; i++) hist[i] <= '0;
          pos     <= '0;
          pending <= 1'b0;
          total   <= '0;
        end else begin
          for (int i = 0; i < MAX_PATTERN; i++) hist[i] <= win[i];
          pos     <= pos_next;
          pending <= hit;
          total   <= total_next;
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_count;
  assign m_axis_tuser  = out_confirmed;
  assign m_axis_tlast  = out_done;

endmodule

/* sv/wwmc_checker.sv */
// Port-level checks for the whole-word match counter, bound to the top level.
module wwmc_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 cfg_valid,
  input logic                                 cfg_ready,
  input logic [wwmc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input logic [wwmc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input logic                                 s_axis_tvalid,
  input logic                                 s_axis_tready,
  input logic [wwmc_pkg::BYTE_BITS-1:0]       s_axis_tdata,   // [7:0] text_byte
  input logic                                 s_axis_tlast,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [wwmc_pkg::WORD_BITS-1:0]       m_axis_tdata,   // [15:0] word_count
  input logic                                 m_axis_tuser,   // [0] match_confirmed
  input logic                                 m_axis_tlast
);
  import wwmc_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // each accepted item shows a result on the next cycle
  a_item_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted item produced no result");

  // a full, stalled output blocks the input
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while result stalled");

  // a confirmed match means a nonzero count
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata != '0)
    else $error("match confirmed with zero count");

endmodule

bind whole_word_match_counter_unit wwmc_checker u_wwmc_checker (.*);

/* verif/tb.sv */
// Self-checking testbench for the whole-word match counter unit.
module tb;
  import wwmc_pkg::*;

  // One expected result per accepted text byte
  typedef struct packed {
    logic [WORD_BITS-1:0] count;
    logic                 confirmed;
    logic                 done;
  } count_result_t;

  // Running whole-word tally: mirrors the block's string state and queues the results it predicts
  class whole_word_tally;
    logic [CFG_DATA_BITS-1:0] pat_lo;
    logic [CFG_DATA_BITS-1:0] pat_hi;
    logic [LEN_BITS-1:0]      pat_len;
    logic [BYTE_BITS-1:0]     hist [MAX_PATTERN+1];
    logic [LEN_BITS-1:0]      pos;
    bit                       pending;
    logic [COUNT_BITS-1:0]    total;
    count_result_t            expected_counts [$];
    int                       fail_count;

    function new();
      pat_lo = '0;
      pat_hi = '0;
      pat_len = 5'd1;
      fail_count = 0;
      clear_string();
    endfunction

    function void clear_string();
      foreach (hist[i]) hist[i] = '0;
      pos = '0;
      pending = 0;
      total = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] v);
      case (idx)
        CFG_PATTERN_LOW: pat_lo = v;
        CFG_PATTERN_HIGH: pat_hi = v;
        CFG_PATTERN_LEN: pat_len = v[LEN_BITS-1:0];
        default: ;
      endcase
    endfunction

    function logic [BYTE_BITS-1:0] pattern_at(int k);
      if (k < 8) return pat_lo[8*k +: 8];
      return pat_hi[8*(k-8) +: 8];
    endfunction

    // saturating increment
    function void bump();
      if (total != {COUNT_BITS{1'b1}}) total++;
    endfunction

    function void note_byte(logic [BYTE_BITS-1:0] b, logic last);
      int len;
      bit hit;
      bit confirmed;
      count_result_t r;
      len = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
      confirmed = 0;
      // right edge of a match that ended on the previous byte
      if (pending && (b == SPACE_BYTE || b == ZERO_BYTE)) begin
        bump();
        confirmed = 1;
      end
      pending = 0;
      for (int i = MAX_PATTERN; i > 0; i--) hist[i] = hist[i-1];
      hist[0] = b;
      if (pos < POS_MAX) pos++;
      // window compare plus left edge check
      hit = (len != 0) && (int'(pos) >= len);
      for (int i = 0; hit && i < len; i++) begin
        if (hist[i] != pattern_at(len - 1 - i)) hit = 0;
      end
      if (hit && int'(pos) != len && hist[len] != SPACE_BYTE) hit = 0;
      if (hit) begin
        if (last) begin
          bump();
          confirmed = 1;
        end else begin
          pending = 1;
        end
      end
      r.count = total[WORD_BITS-1:0];
      r.confirmed = confirmed;
      r.done = last;
      expected_counts.push_back(r);
      if (last) clear_string();
    endfunction

    function void check_count(logic [WORD_BITS-1:0] count, logic confirmed, logic done);
      count_result_t want;
      if (expected_counts.size() == 0) begin
        $error("unexpected result item: word_count %0d", count);
        fail_count++;
        return;
      end
      want = expected_counts.pop_front();
      if (count !== want.count) begin
        $error("word_count expected %0d actual %0d", want.count, count);
        fail_count++;
      end
      if (confirmed !== want.confirmed) begin
        $error("match_confirmed expected %0b actual %0b", want.confirmed, confirmed);
        fail_count++;
      end
      if (done !== want.done) begin
        $error("string_done expected %0b actual %0b", want.done, done);
        fail_count++;
      end
    endfunction
  endclass

  // unused register index, writes to it must change nothing
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam logic [BYTE_BITS-1:0] CHAR_A = 8'h61;
  localparam logic [BYTE_BITS-1:0] CHAR_B = 8'h62;
  localparam int HOLD_CYCLES = 200;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_BITS-1:0]    cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]   cfg_data = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [BYTE_BITS-1:0]       s_axis_tdata = '0;
  logic                       s_axis_tlast = 1'b0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [WORD_BITS-1:0]       m_axis_tdata;
  logic                       m_axis_tuser;
  logic                       m_axis_tlast;

  whole_word_tally tally = new();

  // pattern as last written, used to shape the text
  logic [BYTE_BITS-1:0] pat [MAX_PATTERN];
  int pat_use;
  bit tx_gaps;
  bit rx_gaps;
  bit hold_request;

  int phase_len [13] = '{1, 2, 3, 16, 0, 31, 17, 5, 8, 1, 4, 16, 12};

  whole_word_match_counter_unit u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    repeat (2_000_000) @(posedge clk);
    $display("FAILED: results differ");
    $finish;
  end

  // handshake monitor: accepted bytes, register writes, returned results
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) tally.note_byte(s_axis_tdata, s_axis_tlast);
      if (cfg_valid && cfg_ready) tally.write_reg(cfg_index, cfg_data);
      if (m_axis_tvalid && m_axis_tready)
        tally.check_count(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  // result side: random stalls plus one long hold-off on request
  initial begin : rx_side
    int n;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        n = gap_len();
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [BYTE_BITS-1:0] b, input logic last);
    int n;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      n = gap_len();
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s, input bit end_it);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], end_it && i == s.len() - 1);
  endtask

  // one register write, then valid drops again on the channel
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (tally.expected_counts.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [BYTE_BITS-1:0] pattern_char(int style);
    case (style)
      1: return BYTE_BITS'($urandom_range(0, 255));
      2: return 8'hFF;
      3: return 8'h00;
      default: begin
        if ($urandom_range(0, 7) == 0) return SPACE_BYTE;
        return $urandom_range(0, 1) ? CHAR_A : CHAR_B;
      end
    endcase
  endfunction

  task automatic set_pattern(input int len, input int style);
    logic [CFG_DATA_BITS-1:0] lo;
    logic [CFG_DATA_BITS-1:0] hi;
    logic [CFG_DATA_BITS-1:0] len_word;
    for (int i = 0; i < MAX_PATTERN; i++) pat[i] = pattern_char(style);
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = pat[i];
      hi[8*i +: 8] = pat[i+8];
    end
    // upper bits of the length write carry junk that the block drops
    len_word = {$urandom, $urandom};
    len_word[LEN_BITS-1:0] = LEN_BITS'(len);
    pat_use = (len > MAX_PATTERN) ? MAX_PATTERN : len;
    write_reg(CFG_PATTERN_LOW, lo);
    write_reg(CFG_PATTERN_HIGH, hi);
    write_reg(CFG_PATTERN_LEN, len_word);
  endtask

  // text built mostly from pattern words, near misses and separators, with some noise
  task automatic send_random_text(input int n_bytes, input int end_odds);
    logic [BYTE_BITS-1:0] token [$];
    int kind;
    int wlen;
    int sent;
    bit close_now;
    bit lastflag;
    sent = 0;
    while (sent < n_bytes) begin
      token.delete();
      close_now = 0;
      kind = $urandom_range(0, 99);
      if (kind < 50 && pat_use > 0) begin
        for (int i = 0; i < pat_use; i++) token.push_back(pat[i]);
        close_now = ($urandom_range(0, 4) == 0);
      end else if (kind < 65 && pat_use > 0) begin
        // near miss: pattern with something stuck on either side
        wlen = $urandom_range(0, 2);
        if (wlen != 1) token.push_back($urandom_range(0, 1) ? CHAR_A : pat[0]);
        for (int i = 0; i < pat_use; i++) token.push_back(pat[i]);
        if (wlen != 0) token.push_back($urandom_range(0, 1) ? CHAR_B : pat[pat_use-1]);
      end else if (kind < 85) begin
        wlen = $urandom_range(1, 4);
        for (int i = 0; i < wlen; i++) token.push_back($urandom_range(0, 1) ? CHAR_A : CHAR_B);
      end else begin
        wlen = $urandom_range(1, 3);
        for (int i = 0; i < wlen; i++) token.push_back(BYTE_BITS'($urandom_range(0, 255)));
      end
      if (!close_now) begin
        kind = $urandom_range(0, 9);
        if (kind < 6) token.push_back(SPACE_BYTE);
        else if (kind < 8) token.push_back(ZERO_BYTE);
        else if (kind == 9) begin
          token.push_back(SPACE_BYTE);
          token.push_back(SPACE_BYTE);
        end
      end
      for (int i = 0; i < token.size(); i++) begin
        lastflag = (close_now && i == token.size() - 1) || ($urandom_range(1, end_odds) == 1);
        send_byte(token[i], lastflag);
        sent++;
      end
      if ($urandom_range(0, 149) == 0) drain();
    end
  endtask

  initial begin : stimulus
    int style;
    tx_gaps = 1;
    rx_gaps = 1;
    hold_request = 0;
    pat_use = 1;
    foreach (pat[i]) pat[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset pattern is a single zero byte
    send_byte(ZERO_BYTE, 1'b1);
    drain();
    write_reg(CFG_UNUSED, {CFG_DATA_BITS{1'b1}});
    write_reg(CFG_PATTERN_LOW, 64'h0000_0000_0074_6163);
    write_reg(CFG_PATTERN_LEN, 64'd3);
    send_text("cat", 1);
    // zero byte ends a word but does not start one
    send_text(" cat", 0);
    send_byte(ZERO_BYTE, 1'b0);
    send_text("cat", 1);
    send_text("xcat cat", 1);
    drain();
    // space pattern: pending match and end-of-string match land on one byte
    write_reg(CFG_PATTERN_LOW, 64'(SPACE_BYTE));
    write_reg(CFG_PATTERN_LEN, 64'd1);
    send_text("  ", 1);
    send_byte(8'hFF, 1'b1);

    // random phases over a spread of pattern lengths, strings run across phases
    for (int p = 0; p < 13; p++) begin
      drain();
      case (p)
        3: style = 2;
        9: style = 3;
        1, 6, 11: style = 1;
        default: style = 0;
      endcase
      set_pattern(phase_len[p], style);
      tx_gaps = (p % 3 != 0);
      rx_gaps = (p % 4 != 0);
      if (p == 5) hold_request = 1;
      send_random_text(100, (p % 2 == 0) ? 25 : 60);
    end

    drain();
    repeat (16) @(posedge clk);
    if (tally.fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
